[src/tso_pkg.sv]
// ============================================================================
// tso_pkg: shared types and constants of the Taylor sine oscillator
// Widths, fixed-point constants, register map, sequencer states and the
// divisor table of the series terms.
// ============================================================================
package tso_pkg;

  // Phase and sample formats
  localparam int unsigned PHASE_W   = 32;
  localparam int unsigned SAMPLE_W  = 18;
  localparam int unsigned ORDER_W   = 4;
  localparam int unsigned MAX_ORDER = 11;
  localparam int unsigned FIRST_TERM = 3;
  localparam int          SAMPLE_MAX = 131071;
  localparam int          SAMPLE_MIN = -131072;

  // Q28 arithmetic
  localparam int unsigned Q_FRAC  = 28;
  localparam int unsigned ABS_W   = 30;
  localparam int unsigned TERM_W  = 32;
  localparam int unsigned SUM_W   = 34;
  localparam logic [ABS_W-1:0] PI_Q28 = 30'd843314857;

  // Shared multiplier
  localparam int unsigned MUL_W  = 32;
  localparam int unsigned PROD_W = 2 * MUL_W;

  // Term divider: dividend is the product scaled down by 2^28
  localparam int unsigned DIVIDEND_W = PROD_W - Q_FRAC;
  localparam int unsigned DIVISOR_W  = 7;
  localparam int unsigned DIV_RADIX  = 4;
  localparam int unsigned DIV_STEPS  = DIVIDEND_W / DIV_RADIX;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  // Configuration port
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [PHASE_W-1:0] PHASE_INC_RST    = 32'd97392;
  localparam logic [PHASE_W-1:0] PHASE_OFS_RST    = 32'd0;
  localparam logic [ORDER_W-1:0] SERIES_ORDER_RST = 4'd11;

  typedef logic [PHASE_W-1:0]         phase_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [ORDER_W-1:0]         order_t;

  typedef enum logic [1:0] {
    REG_PHASE_INC    = 2'd0,
    REG_PHASE_OFS    = 2'd1,
    REG_SERIES_ORDER = 2'd2
  } reg_idx_e;

  typedef struct packed {
    phase_t phase_increment;
    phase_t phase_offset;
    order_t series_order;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ANG_MUL,
    S_ANG_FIX,
    S_SQ_MUL,
    S_SQ_FIX,
    S_TERM_MUL,
    S_DIV_GO,
    S_DIV_WAIT,
    S_DONE
  } state_e;

  // n*(n-1) for the odd term n of the series.
  function automatic logic [DIVISOR_W-1:0] term_divisor(order_t n);
    logic [DIVISOR_W-1:0] k;
    unique case (n)
      4'd3:    k = 7'd6;
      4'd5:    k = 7'd20;
      4'd7:    k = 7'd42;
      4'd9:    k = 7'd72;
      4'd11:   k = 7'd110;
      default: k = 7'd1;
    endcase
    return k;
  endfunction

endpackage

[src/tso_intf.sv]
// ============================================================================
// tso_intf: valid/ready channels of the Taylor sine oscillator
// One interface for the tick input and one for the sample result.
// ============================================================================
interface tso_in_if;
  import tso_pkg::*;

  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

interface tso_out_if;
  import tso_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_value;
  phase_t  phase_now;

  modport source (output valid, output sample_value, output phase_now, input ready);
  modport sink   (input valid, input sample_value, input phase_now, output ready);
endinterface

[src/tso_regs.sv]
// ============================================================================
// tso_regs: configuration registers behind an APB-style port
// Holds the phase increment, phase offset and series order.
// ============================================================================
module tso_regs (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [tso_pkg::PADDR_W-1:0] paddr,
  input  logic [tso_pkg::PDATA_W-1:0] pwdata,
  output logic [tso_pkg::PDATA_W-1:0] prdata,
  output logic                    pready,
  output tso_pkg::cfg_t           cfg_o
);
  import tso_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg_o   = cfg_q;

  // Register writes; an address beyond the map is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_increment <= PHASE_INC_RST;
      cfg_q.phase_offset    <= PHASE_OFS_RST;
      cfg_q.series_order    <= SERIES_ORDER_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PHASE_INC:    cfg_q.phase_increment <= pwdata[PHASE_W-1:0];
        REG_PHASE_OFS:    cfg_q.phase_offset    <= pwdata[PHASE_W-1:0];
        REG_SERIES_ORDER: cfg_q.series_order    <= pwdata[ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data.
  always_comb begin
    unique case (reg_idx)
      REG_PHASE_INC:    prdata = cfg_q.phase_increment;
      REG_PHASE_OFS:    prdata = cfg_q.phase_offset;
      REG_SERIES_ORDER: prdata = {{(PDATA_W-ORDER_W){1'b0}}, cfg_q.series_order};
      default:          prdata = '0;
    endcase
  end

endmodule

[src/tso_mul.sv]
// ============================================================================
// tso_mul: shared registered multiplier
// One 32x32 unsigned multiply per enabled cycle, product held in a register.
// ============================================================================
module tso_mul (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [tso_pkg::MUL_W-1:0]   a_i,
  input  logic [tso_pkg::MUL_W-1:0]   b_i,
  output logic [tso_pkg::PROD_W-1:0]  prod_o
);
  import tso_pkg::*;

  logic [PROD_W-1:0] prod_q;

  assign prod_o = prod_q;

  // Product register, loaded only when the sequencer issues a multiply.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
    end
  end

endmodule

[src/tso_div.sv]
// ============================================================================
// tso_div: iterative divider by a small constant
// Restoring division producing four quotient bits per cycle; a done pulse
// follows the last step.
// ============================================================================
module tso_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [tso_pkg::DIVIDEND_W-1:0]  dividend_i,
  input  logic [tso_pkg::DIVISOR_W-1:0]   divisor_i,
  output logic [tso_pkg::TERM_W-1:0]      quotient_o,
  output logic                            done_o
);
  import tso_pkg::*;

  logic [DIVIDEND_W-1:0] dvd_q, dvd_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic                  busy_q;
  logic                  done_q;
  logic [DIVISOR_W:0]    trial;

  assign quotient_o = dvd_q[TERM_W-1:0];
  assign done_o     = done_q;

  // Four restoring steps; the quotient bits shift in behind the dividend.
  always_comb begin
    rem_d = rem_q;
    dvd_d = dvd_q;
    trial = '0;
    for (int i = 0; i < DIV_RADIX; i++) begin
      trial = {rem_d, dvd_d[DIVIDEND_W-1]};
      dvd_d = {dvd_d[DIVIDEND_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        trial    = trial - {1'b0, divisor_i};
        dvd_d[0] = 1'b1;
      end
      rem_d = trial[DIVISOR_W-1:0];
    end
  end

  // Step control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Dividend and remainder.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

endmodule

[src/taylor_sine_oscillator_top.sv]
// ============================================================================
// taylor_sine_oscillator_top: phase accumulator with Taylor-series sine
// Each tick advances a 32-bit phase, maps phase plus offset to an angle in
// [-pi, pi) and sums the odd Taylor terms up to the configured order in Q28,
// giving a saturated Q3.15 sample.
//
//   Channel     Direction  Payload                      Handshake
//   in_chan_i   in         tick                         valid/ready
//   out_chan_o  out        sample_value, phase_now      valid/ready
//   APB port    in/out     phase_increment, phase_offset, series_order
//
// A transaction with tick low is taken while idle and yields nothing.
// A tick works through k = (min(order,11) - 1) / 2 terms beyond x: each term
// is a multiplier step, a divider start and a wait on the nine four-bit
// divider steps. Input is not ready while a tick is in work.
// A finished sample waits in the output register; the next tick may be taken
// meanwhile and stalls only at its own end. Reset clears the phase to zero.
// ============================================================================
module taylor_sine_oscillator_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  tso_in_if.sink                       in_chan_i,
  tso_out_if.source                    out_chan_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tso_pkg::PADDR_W-1:0]  paddr,
  input  logic [tso_pkg::PDATA_W-1:0]  pwdata,
  output logic [tso_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import tso_pkg::*;

  cfg_t   cfg;
  state_e state_q, state_d;

  phase_t phase_q;
  phase_t u_q;
  logic [ABS_W-1:0]  ax_q;
  logic              neg_q;
  logic [TERM_W-1:0] term_q;
  logic [TERM_W-1:0] x2_q;
  logic signed [SUM_W-1:0] sum_q;
  order_t            n_q;
  logic              minus_q;

  logic    out_valid_q;
  sample_t out_sample_q;
  phase_t  out_phase_q;

  logic              in_fire;
  logic              tick_fire;
  logic              out_load;
  order_t            order_eff;
  order_t            n_next;

  logic              mul_en;
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod;
  logic              div_start;
  logic [TERM_W-1:0] quo;
  logic              div_done;

  logic [ABS_W:0]          ang;
  logic [ABS_W-1:0]        ax_new;
  logic                    neg_new;
  logic signed [SUM_W-1:0] sum_signed;
  logic signed [SUM_W:0]   biased;
  logic signed [SUM_W-13:0] scaled;
  sample_t                 sample_sat;

  // Configuration registers.
  tso_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Shared multiplier.
  tso_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Term divider.
  tso_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod[PROD_W-1:Q_FRAC]),
    .divisor_i  (term_divisor(n_q)),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  assign in_fire   = in_chan_i.valid && in_chan_i.ready;
  assign tick_fire = in_fire && in_chan_i.tick;
  assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_chan_o.ready);
  assign order_eff = (cfg.series_order > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER)
                                                              : cfg.series_order;
  assign n_next    = n_q + ORDER_W'(2);

  // Angle magnitude and sign from the scaled phase product.
  assign ang     = prod[ABS_W+31:31];
  assign neg_new = (ang < {1'b0, PI_Q28});
  assign ax_new  = neg_new ? ABS_W'({1'b0, PI_Q28} - ang) : ABS_W'(ang - {1'b0, PI_Q28});

  // Sign, round half up to Q15 and saturate.
  assign sum_signed = neg_q ? -sum_q : sum_q;
  assign biased     = {sum_signed[SUM_W-1], sum_signed} + (SUM_W+1)'(4096);
  assign scaled     = biased[SUM_W:13];
  always_comb begin
    if (scaled > SAMPLE_MAX) begin
      sample_sat = SAMPLE_W'(SAMPLE_MAX);
    end else if (scaled < SAMPLE_MIN) begin
      sample_sat = SAMPLE_W'(SAMPLE_MIN);
    end else begin
      sample_sat = scaled[SAMPLE_W-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (tick_fire) state_d = S_ANG_MUL;
      S_ANG_MUL:  state_d = S_ANG_FIX;
      S_ANG_FIX:  state_d = S_SQ_MUL;
      S_SQ_MUL:   state_d = S_SQ_FIX;
      S_SQ_FIX:   state_d = (order_eff < ORDER_W'(FIRST_TERM)) ? S_DONE : S_TERM_MUL;
      S_TERM_MUL: state_d = S_DIV_GO;
      S_DIV_GO:   state_d = S_DIV_WAIT;
      S_DIV_WAIT: if (div_done) state_d = (n_next > order_eff) ? S_DONE : S_TERM_MUL;
      S_DONE:     if (out_load) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs: multiplier operands, divider start, input ready.
  always_comb begin
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    unique case (state_q)
      S_ANG_MUL: begin
        mul_en = 1'b1;
        mul_a  = u_q;
        mul_b  = MUL_W'(PI_Q28);
      end
      S_SQ_MUL: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(ax_q);
        mul_b  = MUL_W'(ax_q);
      end
      S_TERM_MUL: begin
        mul_en = 1'b1;
        mul_a  = term_q;
        mul_b  = x2_q;
      end
      S_DIV_GO: div_start = 1'b1;
      default: ;
    endcase
  end

  assign in_chan_i.ready = (state_q == S_IDLE);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (tick_fire) begin
        phase_q <= phase_q + cfg.phase_increment;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_chan_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Series datapath.
  always_ff @(posedge clk_i) begin
    if (tick_fire) begin
      u_q <= phase_q + cfg.phase_increment + cfg.phase_offset;
    end
    unique case (state_q)
      S_ANG_FIX: begin
        ax_q    <= ax_new;
        neg_q   <= neg_new;
        term_q  <= TERM_W'(ax_new);
        sum_q   <= SUM_W'(ax_new);
        n_q     <= ORDER_W'(FIRST_TERM);
        minus_q <= 1'b1;
      end
      S_SQ_FIX: x2_q <= prod[Q_FRAC+TERM_W-1:Q_FRAC];
      S_DIV_WAIT: begin
        if (div_done) begin
          term_q  <= quo;
          sum_q   <= minus_q ? sum_q - SUM_W'(quo) : sum_q + SUM_W'(quo);
          n_q     <= n_next;
          minus_q <= !minus_q;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_sample_q <= sample_sat;
      out_phase_q  <= phase_q;
    end
  end

  assign out_chan_o.valid        = out_valid_q;
  assign out_chan_o.sample_value = out_sample_q;
  assign out_chan_o.phase_now    = out_phase_q;

  // A tick makes the block busy on the next cycle.
  a_busy_after_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_fire |=> !in_chan_i.ready)
    else $error("input ready right after a tick was taken");

  // The divider finishes only while the sequencer waits for it.
  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV_WAIT)
    else $error("divider result arrived outside its wait state");

  // Each tick advances the phase by the configured increment.
  a_phase_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_fire |=> phase_q == $past(phase_q) + $past(cfg.phase_increment))
    else $error("phase accumulator did not advance by the increment");

  // A finished sample waits while the output register is still occupied.
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !out_chan_o.ready) |=> state_q == S_DONE)
    else $error("finished sample left while the output was stalled");

endmodule
